FILE: sv/csrspmv_pkg.sv
// Shared types, constants and helper functions for the sparse matrix-vector block.
// No dependencies; used by every module of the block.
`default_nettype none

package csrspmv_pkg;

   localparam int VEC_LEN_DEF = 4096;
   localparam int IDX_W       = 12;
   localparam int VAL_W       = 32;
   localparam int EPOCH_W     = 4;
   localparam int Q_DEPTH     = 4;
   localparam int PTR_W       = $clog2(Q_DEPTH);
   localparam int CNT_W       = $clog2(Q_DEPTH + 1);

   localparam logic [VAL_W-1:0]   QNAN      = 32'h7FC0_0000;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_LOAD    = 2'd1,
      CMD_NONZERO = 2'd2,
      CMD_EMPTY   = 2'd3
   } cmd_type;

   typedef enum logic {
      FS_SWEEP,
      FS_RUN
   } front_state_type;

   // one unit of work for the arithmetic back end
   typedef struct packed {
      logic             empty_row;
      logic             last;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } op_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: sv/csrspmv_front.sv
// Front end: takes requests, keeps the vector store with epoch tags, fetches operands.
// Depends on csrspmv_pkg.
`default_nettype none

module csrspmv_front #(
   parameter int VEC_LEN = csrspmv_pkg::VEC_LEN_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [1:0]                            req_cmd,
   input  wire  [csrspmv_pkg::IDX_W-1:0]         req_index,
   input  wire  [csrspmv_pkg::VAL_W-1:0]         req_value,
   input  wire                                   req_last,
   input  wire  [csrspmv_pkg::CNT_W-1:0]         q_count,
   output logic                                  push,
   output csrspmv_pkg::op_type                   push_op
);

   localparam int AW     = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
   localparam int MW     = csrspmv_pkg::EPOCH_W + csrspmv_pkg::VAL_W;
   localparam int ROOM_W = csrspmv_pkg::CNT_W + 1;

   csrspmv_pkg::front_state_type state_ff, state_in;

   logic [MW-1:0]                    mem [VEC_LEN];
   logic [MW-1:0]                    rd_ff;
   logic [AW-1:0]                    sweep_cnt_ff, sweep_cnt_in;
   logic [csrspmv_pkg::EPOCH_W-1:0]  epoch_ff, epoch_in;

   logic                             f1_valid_ff, f1_valid_in;
   logic                             f1_empty_ff;
   logic                             f1_last_ff;
   logic                             f1_range_ff;
   logic [csrspmv_pkg::VAL_W-1:0]    f1_value_ff;
   logic [csrspmv_pkg::EPOCH_W-1:0]  f1_epoch_ff;

   logic                             accept;
   logic                             in_range;
   logic [AW-1:0]                    addr;
   logic                             mem_we;
   logic [AW-1:0]                    mem_wa;
   logic [MW-1:0]                    mem_wd;
   logic                             sweeping;
   logic                             room;

   assign in_range = (32'(req_index) < 32'(VEC_LEN));
   assign addr     = AW'(req_index);
   assign room     = (ROOM_W'(q_count) + ROOM_W'(f1_valid_ff)) < ROOM_W'(csrspmv_pkg::Q_DEPTH);
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      epoch_in     = epoch_ff;
      sweeping     = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         csrspmv_pkg::FS_SWEEP: begin
            sweeping     = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + AW'(1);
            if (sweep_cnt_ff == AW'(VEC_LEN - 1)) begin
               state_in     = csrspmv_pkg::FS_RUN;
               sweep_cnt_in = '0;
            end
         end
         csrspmv_pkg::FS_RUN: begin
            req_ready = room;
            if (req_valid && room && (req_cmd == csrspmv_pkg::CMD_CLEAR)) begin
               if (epoch_ff == csrspmv_pkg::EPOCH_MAX) begin
                  // tags about to repeat: wipe them all
                  epoch_in = csrspmv_pkg::EPOCH_W'(1);
                  state_in = csrspmv_pkg::FS_SWEEP;
               end else begin
                  epoch_in = epoch_ff + csrspmv_pkg::EPOCH_W'(1);
               end
            end
         end
         default: state_in = csrspmv_pkg::FS_SWEEP;
      endcase
   end

   assign mem_we = sweeping || (accept && (req_cmd == csrspmv_pkg::CMD_LOAD) && in_range);
   assign mem_wa = sweeping ? sweep_cnt_ff : addr;
   assign mem_wd = sweeping ? '0 : {epoch_ff, req_value};

   assign f1_valid_in = accept && ((req_cmd == csrspmv_pkg::CMD_NONZERO) ||
                                   (req_cmd == csrspmv_pkg::CMD_EMPTY));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csrspmv_pkg::FS_SWEEP;
         sweep_cnt_ff <= '0;
         epoch_ff     <= csrspmv_pkg::EPOCH_W'(1);
         f1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         epoch_ff     <= epoch_in;
         f1_valid_ff  <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_ff       <= mem[addr];
         f1_empty_ff <= (req_cmd == csrspmv_pkg::CMD_EMPTY);
         f1_last_ff  <= req_last;
         f1_range_ff <= in_range;
         f1_value_ff <= req_value;
         f1_epoch_ff <= epoch_ff;
      end
   end

   // an entry counts only if written since the last clear
   assign push              = f1_valid_ff;
   assign push_op.empty_row = f1_empty_ff;
   assign push_op.last      = f1_last_ff;
   assign push_op.a         = f1_value_ff;
   assign push_op.b         = (f1_range_ff && (rd_ff[MW-1 -: csrspmv_pkg::EPOCH_W] == f1_epoch_ff))
                              ? rd_ff[csrspmv_pkg::VAL_W-1:0] : '0;

endmodule

`default_nettype wire

FILE: sv/csrspmv_queue.sv
// Short register queue between front and back end.
// Depends on csrspmv_pkg.
`default_nettype none

module csrspmv_queue (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   input  csrspmv_pkg::op_type                push_op,
   input  wire                                pop,
   output csrspmv_pkg::op_type                head,
   output logic                               head_valid,
   output logic [csrspmv_pkg::CNT_W-1:0]      count
);

   csrspmv_pkg::op_type                  entry_ff [csrspmv_pkg::Q_DEPTH];
   logic [csrspmv_pkg::PTR_W-1:0]        wr_ff, wr_in;
   logic [csrspmv_pkg::PTR_W-1:0]        rd_ff, rd_in;
   logic [csrspmv_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + csrspmv_pkg::PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + csrspmv_pkg::PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + csrspmv_pkg::CNT_W'(push) - csrspmv_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_op;
      end
   end

   assign head       = entry_ff[rd_ff];
   assign head_valid = (cnt_ff != '0);
   assign count      = cnt_ff;

endmodule

`default_nettype wire

FILE: sv/csrspmv_back.sv
// Back end: fp32 multiply pipeline, accumulate loop and result register.
// Depends on csrspmv_pkg.
`default_nettype none

module csrspmv_back (
   input  wire                               clock,
   input  wire                               reset,
   input  csrspmv_pkg::op_type               head,
   input  wire                               head_valid,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [csrspmv_pkg::VAL_W-1:0]     rsp_data
);

   // ---------------- M1: unpack and normalise operands
   logic               m1_valid_ff, m1_empty_ff, m1_last_ff;
   logic               m1_sign_ff, m1_nan_ff, m1_inf_ff, m1_zero_ff;
   logic [23:0]        m1_ma_ff, m1_mb_ff;
   logic signed [10:0] m1_exp_ff;

   logic [7:0]         ea, eb;
   logic [23:0]        ma0, mb0;
   logic [4:0]         lza, lzb;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic signed [10:0] ean, ebn;

   // ---------------- M2: mantissa product
   logic               m2_valid_ff, m2_empty_ff, m2_last_ff;
   logic               m2_sign_ff, m2_nan_ff, m2_inf_ff, m2_zero_ff;
   logic [47:0]        m2_p_ff;
   logic signed [10:0] m2_exp_ff;

   // ---------------- M3: rounded product
   logic               m3_valid_ff, m3_empty_ff, m3_last_ff;
   logic [31:0]        m3_bits_ff;

   logic signed [10:0] pe;
   logic [47:0]        pm, pshifted, pmask;
   logic [5:0]         psh;
   logic               pr, ps, pinc, povf;
   logic [7:0]         pef;
   logic [30:0]        pround;
   logic [31:0]        pbits;

   // ---------------- A1/A2: accumulate
   logic               a1_valid_ff;
   logic               a1_empty_ff, a1_last_ff;
   logic [27:0]        a1_sum_ff;
   logic [7:0]         a1_e_ff;
   logic               a1_sign_ff, a1_bothzero_ff, a1_zsign_ff;
   logic               a1_nan_ff, a1_inf_ff, a1_infsign_ff;

   logic [31:0]        acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff;

   logic [31:0]        x, y, big, sml;
   logic               xn, yn, xi, yi;
   logic [7:0]         eb_e, es_e, dexp;
   logic [4:0]         dc;
   logic [26:0]        mb_ext, ms_ext, ms_sh, ms_mask;
   logic               ms_st;
   logic [27:0]        sum;

   logic [4:0]         nlz;
   logic [7:0]         nlim, nsh;
   logic [26:0]        norm;
   logic [8:0]         ne;
   logic [23:0]        nkeep;
   logic               nr, ns, ninc;
   logic [30:0]        nround;
   logic [31:0]        res;

   logic               adv, issue, finish;

   always_comb begin
      ea     = head.a[30:23];
      eb     = head.b[30:23];
      ma0    = {ea != 8'd0, head.a[22:0]};
      mb0    = {eb != 8'd0, head.b[22:0]};
      lza    = csrspmv_pkg::lzc24(ma0);
      lzb    = csrspmv_pkg::lzc24(mb0);
      a_nan  = (ea == 8'hFF) && (head.a[22:0] != '0);
      b_nan  = (eb == 8'hFF) && (head.b[22:0] != '0);
      a_inf  = (ea == 8'hFF) && (head.a[22:0] == '0);
      b_inf  = (eb == 8'hFF) && (head.b[22:0] == '0);
      a_zero = (head.a[30:0] == '0);
      b_zero = (head.b[30:0] == '0);
      ean    = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea}) - $signed({6'b0, lza});
      ebn    = $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb}) - $signed({6'b0, lzb});
   end

   // product normalise and round to nearest even
   always_comb begin
      pe   = m2_exp_ff + (m2_p_ff[47] ? 11'sd1 : 11'sd0);
      pm   = m2_p_ff[47] ? m2_p_ff : {m2_p_ff[46:0], 1'b0};
      if (pe > 11'sd0) begin
         psh = 6'd0;
      end else if (pe < -11'sd47) begin
         psh = 6'd49;
      end else begin
         psh = 6'(11'sd1 - pe);
      end
      pshifted = pm >> psh;
      pmask    = ~({48{1'b1}} << psh);
      pr       = pshifted[23];
      ps       = (|pshifted[22:0]) || (|(pm & pmask));
      pinc     = pr && (ps || pshifted[24]);
      povf     = pe > 11'sd254;
      pef      = (pe > 11'sd0) ? pe[7:0] : 8'd0;
      pround   = {pef, pshifted[46:24]} + 31'(pinc);
      if (m2_nan_ff) begin
         pbits = csrspmv_pkg::QNAN;
      end else if (m2_inf_ff || povf) begin
         pbits = {m2_sign_ff, 8'hFF, 23'd0};
      end else if (m2_zero_ff) begin
         pbits = {m2_sign_ff, 31'd0};
      end else begin
         pbits = {m2_sign_ff, pround};
      end
   end

   // align and add against the accumulator
   always_comb begin
      x       = acc_ff;
      y       = m3_bits_ff;
      xn      = (x[30:23] == 8'hFF) && (x[22:0] != '0);
      yn      = (y[30:23] == 8'hFF) && (y[22:0] != '0);
      xi      = (x[30:23] == 8'hFF) && (x[22:0] == '0);
      yi      = (y[30:23] == 8'hFF) && (y[22:0] == '0);
      big     = (x[30:0] >= y[30:0]) ? x : y;
      sml     = (x[30:0] >= y[30:0]) ? y : x;
      eb_e    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es_e    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      dexp    = eb_e - es_e;
      dc      = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
      mb_ext  = {big[30:23] != 8'd0, big[22:0], 3'b000};
      ms_ext  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      ms_mask = ~({27{1'b1}} << dc);
      ms_st   = |(ms_ext & ms_mask);
      ms_sh   = (ms_ext >> dc) | {26'd0, ms_st};
      sum     = (big[31] ^ sml[31]) ? ({1'b0, mb_ext} - {1'b0, ms_sh})
                                    : ({1'b0, mb_ext} + {1'b0, ms_sh});
   end

   // normalise and round the sum
   always_comb begin
      nlz  = csrspmv_pkg::lzc27(a1_sum_ff[26:0]);
      nlim = a1_e_ff - 8'd1;
      nsh  = (8'(nlz) < nlim) ? 8'(nlz) : nlim;
      norm = a1_sum_ff[26:0] << nsh;
      if (a1_sum_ff[27]) begin
         nkeep = a1_sum_ff[27:4];
         nr    = a1_sum_ff[3];
         ns    = |a1_sum_ff[2:0];
         ne    = 9'(a1_e_ff) + 9'd1;
      end else begin
         nkeep = norm[26:3];
         nr    = norm[2];
         ns    = |norm[1:0];
         ne    = norm[26] ? 9'(a1_e_ff - nsh) : 9'd0;
      end
      ninc   = nr && (ns || nkeep[0]);
      nround = {ne[7:0], nkeep[22:0]} + 31'(ninc);
      if (a1_nan_ff) begin
         res = csrspmv_pkg::QNAN;
      end else if (a1_inf_ff) begin
         res = {a1_infsign_ff, 8'hFF, 23'd0};
      end else if (a1_sum_ff == '0) begin
         res = {a1_bothzero_ff ? a1_zsign_ff : 1'b0, 31'd0};
      end else if (ne == 9'd255) begin
         res = {a1_sign_ff, 8'hFF, 23'd0};
      end else begin
         res = {a1_sign_ff, nround};
      end
   end

   // one add in flight at a time; a result needs a free output register
   assign issue  = m3_valid_ff && !a1_valid_ff &&
                   (!(m3_last_ff || m3_empty_ff) || !rsp_valid_ff);
   assign adv    = !m3_valid_ff || issue;
   assign pop    = adv && head_valid;
   assign finish = a1_valid_ff && (a1_last_ff || a1_empty_ff);

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (a1_valid_ff) begin
         acc_in = (a1_last_ff || a1_empty_ff) ? 32'd0 : res;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         a1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 32'd0;
      end else begin
         if (adv) begin
            m1_valid_ff <= head_valid;
            m2_valid_ff <= m1_valid_ff;
            m3_valid_ff <= m2_valid_ff;
         end
         a1_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_empty_ff <= head.empty_row;
         m1_last_ff  <= head.last;
         m1_sign_ff  <= head.a[31] ^ head.b[31];
         m1_nan_ff   <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
         m1_inf_ff   <= a_inf || b_inf;
         m1_zero_ff  <= a_zero || b_zero;
         m1_ma_ff    <= ma0 << lza;
         m1_mb_ff    <= mb0 << lzb;
         m1_exp_ff   <= ean + ebn - 11'sd127;

         m2_empty_ff <= m1_empty_ff;
         m2_last_ff  <= m1_last_ff;
         m2_sign_ff  <= m1_sign_ff;
         m2_nan_ff   <= m1_nan_ff;
         m2_inf_ff   <= m1_inf_ff && !m1_nan_ff;
         m2_zero_ff  <= m1_zero_ff && !m1_nan_ff && !m1_inf_ff;
         m2_p_ff     <= {24'd0, m1_ma_ff} * {24'd0, m1_mb_ff};
         m2_exp_ff   <= m1_exp_ff;

         m3_empty_ff <= m2_empty_ff;
         m3_last_ff  <= m2_last_ff;
         m3_bits_ff  <= pbits;
      end
      if (issue) begin
         a1_empty_ff    <= m3_empty_ff;
         a1_last_ff     <= m3_last_ff;
         a1_sum_ff      <= sum;
         a1_e_ff        <= eb_e;
         a1_sign_ff     <= big[31];
         a1_bothzero_ff <= (x[30:0] == '0) && (y[30:0] == '0);
         a1_zsign_ff    <= x[31] && y[31];
         a1_nan_ff      <= xn || yn || (xi && yi && (x[31] != y[31]));
         a1_inf_ff      <= xi || yi;
         a1_infsign_ff  <= xi ? x[31] : y[31];
      end
      if (finish) begin
         rsp_data_ff <= a1_empty_ff ? 32'd0 : res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix-vector multiplier (fp32).
// Depends on csrspmv_pkg, csrspmv_front, csrspmv_queue, csrspmv_back.
`default_nettype none

// Streams CSR sparse matrix rows against a stored vector in IEEE single
// precision. Each request carries a command in req_tuser: clear vector,
// load vector entry, matrix nonzero (req_tlast marks the row's last one)
// or empty row. Loads and clears are taken one per cycle while the queue
// has room. A nonzero is multiplied by its vector entry (unwritten or
// out-of-range entries read as +0) in a three-stage multiplier, then summed
// into the row accumulator by an add/normalise loop that holds one add at a
// time; that accumulate loop sets the sustained rate. The row sum reaches
// rsp_tvalid through the fetch register, the queue, multiplier stages M1-M3,
// the A1 add register and the result register. A four-entry queue between
// the front end and the arithmetic lets requests keep flowing while results
// are stalled. After reset, and after every fifteenth clear, the vector
// store's tags are wiped in a pass over all VEC_LEN entries during which no
// request is taken. NaN sums come out as 0x7FC00000.
module csr_sparse_matrix_vector_multiply #(
   parameter int VEC_LEN = csrspmv_pkg::VEC_LEN_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // index[11:0], value[43:12], zero[47:44]
   input  wire  [1:0]  req_tuser,   // command[1:0]
   input  wire         req_tlast,   // last_in_row
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata    // row_sum[31:0]
);

   logic                              push, pop, head_valid;
   csrspmv_pkg::op_type               push_op, head;
   logic [csrspmv_pkg::CNT_W-1:0]     q_count;

   csrspmv_front #(
      .VEC_LEN (VEC_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_index (req_tdata[11:0]),
      .req_value (req_tdata[43:12]),
      .req_last  (req_tlast),
      .q_count   (q_count),
      .push      (push),
      .push_op   (push_op)
   );

   csrspmv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .count      (q_count)
   );

   csrspmv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

   // queue never overfills
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (q_count == csrspmv_pkg::CNT_W'(csrspmv_pkg::Q_DEPTH))))
      else $error("request pushed into a full queue");

   // back end only pops real entries
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_count != '0))
      else $error("pop from an empty queue");

   // front-end flow control keeps the count in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      q_count <= csrspmv_pkg::CNT_W'(csrspmv_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire
